>>> src/regular_polygon_vertex_generator_unit_macros.svh
// ----------------------------------------------------------------------------
// regular polygon vertex generator - assertion macros
// concurrent check wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef REGULAR_POLYGON_VERTEX_GENERATOR_UNIT_MACROS_SVH
`define REGULAR_POLYGON_VERTEX_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define RPVG_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// condition must never hold
`define RPVG_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define RPVG_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define RPVG_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

>>> src/rpvg_pkg.sv
// ----------------------------------------------------------------------------
// rpvg_pkg
// shared widths, the queued shape record and the quarter-wave sine builder
// ----------------------------------------------------------------------------
package rpvg_pkg;

    localparam int MAX_VERTICES        = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int POS_W  = 24;
    localparam int RAD_W  = 23;
    localparam int ANG_W  = 16;
    localparam int VCNT_W = 6;
    localparam int VIX_W  = 5;
    localparam int TRIG_W = 16;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W  = $clog2(MAX_VERTICES);

    localparam int QUEUE_DEPTH = 2;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;

    typedef struct packed {
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic [RAD_W-1:0]        radius;
        logic [ANG_W-1:0]        rot;
        logic [CNT_W-1:0]        count;
        logic [ANG_W-1:0]        step_q;
        logic [CNT_W-1:0]        step_r;
    } t_shape;

    // quarter-wave sine in q30, taylor series through x^15 in horner form,
    // scaled and rounded to 32767 full scale; elaboration time only
    function automatic logic [TRIG_W-1:0] quarter_sine(input int unsigned m,
                                                      input int unsigned qbits);
        longint x;
        longint x2;
        longint t;
        longint p;
        longint s;
        x  = (longint'(m) * HALF_PI_Q30 + (longint'(1) <<< (qbits - 1))) >>> qbits;
        x2 = (x * x) >>> 30;
        t  = ONE_Q30;
        p  = (x2 * t) >>> 30;  t = ONE_Q30 - p / 210;
        p  = (x2 * t) >>> 30;  t = ONE_Q30 - p / 156;
        p  = (x2 * t) >>> 30;  t = ONE_Q30 - p / 110;
        p  = (x2 * t) >>> 30;  t = ONE_Q30 - p / 72;
        p  = (x2 * t) >>> 30;  t = ONE_Q30 - p / 42;
        p  = (x2 * t) >>> 30;  t = ONE_Q30 - p / 20;
        p  = (x2 * t) >>> 30;  t = ONE_Q30 - p / 6;
        s  = (x * t) >>> 30;
        return TRIG_W'((longint'(32767) * s + (longint'(1) <<< 29)) >>> 30);
    endfunction

endpackage

>>> src/rpvg_front.sv
// ----------------------------------------------------------------------------
// rpvg_front
// accepts a shape request, resolves the vertex count, drops empty shapes and
// divides one turn by the count to get the per-vertex angle step
// ----------------------------------------------------------------------------
module rpvg_front import rpvg_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [POS_W-1:0] i_center_x,
    input  logic signed [POS_W-1:0] i_center_y,
    input  logic [RAD_W-1:0]        i_radius,
    input  logic [ANG_W-1:0]        i_rotation,
    input  logic [VCNT_W-1:0]       i_vertex_count,
    input  logic                    i_is_circle,
    input  logic                    i_full,
    output logic                    o_push,
    output t_shape                  o_shape
);

    localparam int STEP_N = ANG_W + 1;
    localparam int STEP_W = $clog2(STEP_N);
    localparam int CMP_W  = 7;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_PUSH = 3'b100
    } t_front_state;

    t_front_state             r_state, n_state;
    logic [STEP_W-1:0]        r_step;
    logic [CNT_W-1:0]         r_rem;
    logic [ANG_W-1:0]         r_quo;
    logic signed [POS_W-1:0]  r_cx, r_cy;
    logic [RAD_W-1:0]         r_radius;
    logic [ANG_W-1:0]         r_rot;
    logic [CNT_W-1:0]         r_count;

    logic [CMP_W-1:0]         vc_ext;
    logic [CNT_W-1:0]         n_count;
    logic                     accept;
    logic [CNT_W:0]           shifted;
    logic                     ge;
    logic [CNT_W:0]           diff;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    // circle flag or an oversized count both land on the vertex limit
    assign vc_ext  = CMP_W'(i_vertex_count);
    assign n_count = (i_is_circle || (vc_ext > CMP_W'(MAX_VERTICES)))
                   ? CNT_W'(MAX_VERTICES) : CNT_W'(vc_ext);

    // restoring division of one turn (a one followed by ANG_W zeros)
    assign shifted = {r_rem, (r_step == '0)};
    assign ge      = (shifted >= {1'b0, r_count});
    assign diff    = shifted - {1'b0, r_count};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (n_count != '0)) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_step == STEP_W'(STEP_N - 1)) n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (!i_full) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx     <= i_center_x;
            r_cy     <= i_center_y;
            r_radius <= i_radius;
            r_rot    <= i_rotation;
            r_count  <= n_count;
            r_step   <= '0;
            r_rem    <= '0;
            r_quo    <= '0;
        end else if (r_state == ST_DIV) begin
            r_step <= r_step + STEP_W'(1);
            r_rem  <= ge ? CNT_W'(diff) : CNT_W'(shifted);
            r_quo  <= {r_quo[ANG_W-2:0], ge};
        end
    end

    assign o_push         = (r_state == ST_PUSH) && !i_full;
    assign o_shape.cx     = r_cx;
    assign o_shape.cy     = r_cy;
    assign o_shape.radius = r_radius;
    assign o_shape.rot    = r_rot;
    assign o_shape.count  = r_count;
    assign o_shape.step_q = r_quo;
    assign o_shape.step_r = r_rem;

endmodule

>>> src/rpvg_fifo.sv
// ----------------------------------------------------------------------------
// rpvg_fifo
// short shape queue between the front and the back
// ----------------------------------------------------------------------------
module rpvg_fifo import rpvg_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_shape i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_shape o_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    t_shape            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [OCC_W-1:0]  r_occ;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_occ == OCC_W'(QUEUE_DEPTH));
    assign o_empty = (r_occ == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_occ    <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            case ({i_push, i_pop})
                2'b10:   r_occ <= r_occ + OCC_W'(1);
                2'b01:   r_occ <= r_occ - OCC_W'(1);
                default: r_occ <= r_occ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

>>> src/rpvg_sine_rom.sv
// ----------------------------------------------------------------------------
// rpvg_sine_rom
// quarter-wave sine rom, two registered read ports
// ----------------------------------------------------------------------------
module rpvg_sine_rom import rpvg_pkg::*; #(
    parameter int TBL_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [TBL_BITS-2:0]     i_addr_s,
    input  logic [TBL_BITS-2:0]     i_addr_c,
    output logic [TRIG_W-1:0]       o_data_s,
    output logic [TRIG_W-1:0]       o_data_c
);

    localparam int QN = 1 << (TBL_BITS - 2);

    typedef logic [TRIG_W-1:0] t_qrom [QN + 1];

    function automatic t_qrom build_qrom();
        t_qrom tbl;
        for (int m = 0; m <= QN; m++) begin
            tbl[m] = quarter_sine(m, TBL_BITS - 2);
        end
        return tbl;
    endfunction

    localparam t_qrom QROM = build_qrom();

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data_s <= QROM[i_addr_s];
            o_data_c <= QROM[i_addr_c];
        end
    end

endmodule

>>> src/rpvg_back.sv
// ----------------------------------------------------------------------------
// rpvg_back
// walks the vertices of the queued shape and runs each through
// rom lookup, multiply and add/saturate stages into the output register
// ----------------------------------------------------------------------------
module rpvg_back import rpvg_pkg::*; #(
    parameter int TBL_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_shape                  i_shape,
    input  logic                    i_empty,
    output logic                    o_pop,
    input  logic                    i_ready,
    output logic                    o_valid,
    output logic [VIX_W-1:0]        o_vertex_index,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic                    o_last
);

    localparam int QA_W   = TBL_BITS - 1;
    localparam int QR_W   = TBL_BITS - 2;
    localparam int QN     = 1 << QR_W;
    localparam int PROD_W = RAD_W + 1 + TRIG_W;
    localparam int SUM_W  = POS_W + 1;
    localparam int PSH    = 15;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // vertex sequencer
    logic [IDX_W-1:0]  r_idx;
    logic [ANG_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_frac;

    logic              adv;
    logic              issue;
    logic              is_last;
    logic [CNT_W:0]    frac_sum;
    logic              frac_wrap;
    logic [ANG_W-1:0]  ang;
    logic [TBL_BITS-1:0] k;
    logic [1:0]        quad_s, quad_c;
    logic [QR_W-1:0]   rr;
    logic [QA_W-1:0]   addr_s, addr_c;
    logic [TRIG_W-1:0] rom_s, rom_c;

    // lookup stage
    logic                    r_s1_valid;
    logic [IDX_W-1:0]        r_s1_idx;
    logic                    r_s1_last;
    logic                    r_s1_neg_s, r_s1_neg_c;
    logic signed [POS_W-1:0] r_s1_cx, r_s1_cy;
    logic [RAD_W-1:0]        r_s1_radius;

    // multiply stage
    logic                     r_s2_valid;
    logic [IDX_W-1:0]         r_s2_idx;
    logic                     r_s2_last;
    logic signed [POS_W-1:0]  r_s2_cx, r_s2_cy;
    logic signed [PROD_W-1:0] r_s2_px, r_s2_py;

    logic signed [TRIG_W-1:0] trig_s, trig_c;
    logic signed [RAD_W:0]    rad_s;
    logic signed [PROD_W-1:0] n_px, n_py;
    logic signed [SUM_W-1:0]  sum_x, sum_y;

    // output register
    logic                    r_out_valid;
    logic [VIX_W-1:0]        r_out_idx;
    logic signed [POS_W-1:0] r_out_x, r_out_y;
    logic                    r_out_last;

    function automatic logic [QA_W-1:0] mirror_addr(input logic [1:0]      q,
                                                    input logic [QR_W-1:0] r);
        return q[0] ? (QA_W'(QN) - QA_W'(r)) : QA_W'(r);
    endfunction

    function automatic logic signed [POS_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        if (v[SUM_W-1] != v[SUM_W-2]) return v[SUM_W-1] ? POS_MIN : POS_MAX;
        return v[POS_W-1:0];
    endfunction

    assign adv     = !r_out_valid || i_ready;
    assign issue   = adv && !i_empty;
    assign is_last = ((CNT_W'(r_idx) + CNT_W'(1)) == i_shape.count);
    assign o_pop   = issue && is_last;

    assign frac_sum  = {1'b0, r_frac} + {1'b0, i_shape.step_r};
    assign frac_wrap = (frac_sum >= {1'b0, i_shape.count});

    assign ang    = i_shape.rot + r_acc;
    assign k      = ang[ANG_W-1 -: TBL_BITS];
    assign quad_s = k[TBL_BITS-1 -: 2];
    assign quad_c = quad_s + 2'd1;
    assign rr     = k[QR_W-1:0];
    assign addr_s = mirror_addr(quad_s, rr);
    assign addr_c = mirror_addr(quad_c, rr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_acc  <= '0;
            r_frac <= '0;
        end else if (issue) begin
            if (is_last) begin
                r_idx  <= '0;
                r_acc  <= '0;
                r_frac <= '0;
            end else begin
                r_idx  <= r_idx + IDX_W'(1);
                r_acc  <= r_acc + i_shape.step_q + ANG_W'(frac_wrap);
                r_frac <= frac_wrap ? CNT_W'(frac_sum - {1'b0, i_shape.count})
                                    : CNT_W'(frac_sum);
            end
        end
    end

    rpvg_sine_rom #(
        .TBL_BITS (TBL_BITS)
    ) u_rom (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_addr_s (addr_s),
        .i_addr_c (addr_c),
        .o_data_s (rom_s),
        .o_data_c (rom_c)
    );

    assign trig_s = r_s1_neg_s ? -$signed(rom_s) : $signed(rom_s);
    assign trig_c = r_s1_neg_c ? -$signed(rom_c) : $signed(rom_c);
    assign rad_s  = $signed({1'b0, r_s1_radius});
    assign n_px   = rad_s * trig_c;
    assign n_py   = rad_s * trig_s;

    assign sum_x = SUM_W'(r_s2_cx) + SUM_W'(r_s2_px >>> PSH);
    assign sum_y = SUM_W'(r_s2_cy) + SUM_W'(r_s2_py >>> PSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= issue;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_idx    <= r_idx;
            r_s1_last   <= is_last;
            r_s1_neg_s  <= quad_s[1];
            r_s1_neg_c  <= quad_c[1];
            r_s1_cx     <= i_shape.cx;
            r_s1_cy     <= i_shape.cy;
            r_s1_radius <= i_shape.radius;

            r_s2_idx    <= r_s1_idx;
            r_s2_last   <= r_s1_last;
            r_s2_cx     <= r_s1_cx;
            r_s2_cy     <= r_s1_cy;
            r_s2_px     <= n_px;
            r_s2_py     <= n_py;

            r_out_idx   <= VIX_W'(r_s2_idx);
            r_out_last  <= r_s2_last;
            r_out_x     <= sat(sum_x);
            r_out_y     <= sat(sum_y);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_vertex_index = r_out_idx;
    assign o_pos_x        = r_out_x;
    assign o_pos_y        = r_out_y;
    assign o_last         = r_out_last;

endmodule

>>> src/regular_polygon_vertex_generator_unit.sv
// ----------------------------------------------------------------------------
// regular_polygon_vertex_generator_unit
// one shape request in, one vertex request out per polygon corner
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_valid / o_ready) takes a shape request: center, radius,
//   start angle, vertex count and circle flag. output channel (o_valid /
//   i_ready) gives one vertex request per corner, index 0 first, o_last on
//   the final one. a resolved count of zero is taken and yields nothing.
//   a shape passes bit-serial angle-step division, a queue push, then the
//   rom lookup, multiply and output stages of the back end.
//   throughput: the back end emits one vertex per cycle unless the receiver
//   stalls; the front takes no new request until its 17-step divider has
//   finished and its shape is pushed, and runs ahead by up to 2 queued shapes.
//   reset: synchronous, clears the front state machine, the queue and all
//   pipeline valid bits; the sine rom is constant and needs no fill.
//   receiver stall: with i_ready low the output register holds its vertex
//   and the back pipeline freezes; the front keeps accepting until the
//   queue fills, then o_ready drops.
// ----------------------------------------------------------------------------
`include "regular_polygon_vertex_generator_unit_macros.svh"

module regular_polygon_vertex_generator_unit import rpvg_pkg::*; #(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // shape request channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [POS_W-1:0] i_center_x,
    input  logic signed [POS_W-1:0] i_center_y,
    input  logic [RAD_W-1:0]        i_radius,
    input  logic [ANG_W-1:0]        i_rotation,
    input  logic [VCNT_W-1:0]       i_vertex_count,
    input  logic                    i_is_circle,
    // vertex request channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [VIX_W-1:0]        o_vertex_index,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_y,
    output logic                    o_last
);

    // queue handshake between the front and the back
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;
    t_shape q_wr_data;
    t_shape q_rd_data;
    logic   q_count_ok;

    // front: accept, resolve count, divide one turn by the count
    rpvg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .i_rotation     (i_rotation),
        .i_vertex_count (i_vertex_count),
        .i_is_circle    (i_is_circle),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_shape        (q_wr_data)
    );

    // decouples divider timing from vertex emission
    rpvg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rd_data)
    );

    // back: angle accumulation, sin/cos lookup, scale, offset, saturate
    rpvg_back #(
        .TBL_BITS (SINE_TABLE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_shape        (q_rd_data),
        .i_empty        (q_empty),
        .o_pop          (q_pop),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_vertex_index (o_vertex_index),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_last         (o_last)
    );

    // a queued shape always has between one and the vertex limit corners
    assign q_count_ok = (q_wr_data.count != '0) && (q_wr_data.count <= CNT_W'(MAX_VERTICES));

    // queue discipline and queued shape sanity
    `RPVG_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, q_pop && q_empty, "pop while queue empty")
    `RPVG_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, q_push && q_full, "push while queue full")
    `RPVG_ASSERT_IMP(a_push_count, i_clk, i_rst_n, q_push, q_count_ok, "bad vertex count")

endmodule

>>> tb/regular_polygon_vertex_generator_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// regular_polygon_vertex_generator_unit_test
// drives shape requests into the vertex generator and checks every vertex
// request that comes out against a behavioral model of the corner placement
// (sine rom, angle step, scaled offset, floor shift and 24-bit saturation);
// directed shapes cover counts, extremes and saturation, then random shapes
// run, most of them with random stalls on both channels
// ----------------------------------------------------------------------------
module regular_polygon_vertex_generator_unit_test;
    import rpvg_pkg::*;

    // sine rom geometry and the fixed-point constants of its quarter wave
    localparam int     ROM_BITS    = 10;
    localparam int     ROM_SIZE    = 1 << ROM_BITS;
    localparam int     ROM_QUARTER = ROM_SIZE / 4;
    localparam longint PI_HALF_Q30 = 64'sd1686629713;
    localparam longint UNITY_Q30   = 64'sd1073741824;
    localparam longint COORD_MAX   = 64'sd8388607;
    localparam longint COORD_MIN   = -64'sd8388608;

    // worst case: every shape 32 corners, every corner held by a long stall
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int TAIL_CYCLES    = 64;
    localparam int RANDOM_SHAPES  = 80;

    typedef struct {
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic [RAD_W-1:0]        radius;
        logic [ANG_W-1:0]        rot;
        logic [VCNT_W-1:0]       count;
        logic                    circle;
        bit                      drain_first;  // sender waits for an empty scoreboard
        bit                      steady;       // no idling on either side
    } t_shape_req;

    typedef struct {
        logic [VIX_W-1:0]        index;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic                    last;
    } t_vertex;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic signed [POS_W-1:0] i_center_x;
    logic signed [POS_W-1:0] i_center_y;
    logic [RAD_W-1:0]        i_radius;
    logic [ANG_W-1:0]        i_rotation;
    logic [VCNT_W-1:0]       i_vertex_count;
    logic                    i_is_circle;
    logic                    o_valid;
    logic                    i_ready;
    logic [VIX_W-1:0]        o_vertex_index;
    logic signed [POS_W-1:0] o_pos_x;
    logic signed [POS_W-1:0] o_pos_y;
    logic                    o_last;

    t_shape_req shape_backlog[$];     // shapes not yet offered
    t_vertex    pending_vertices[$];  // corners predicted, not yet seen
    int         sine_rom[ROM_SIZE];

    bit shape_taken   = 1'b0;  // set at the rising edge that took a shape request
    bit flow_steady   = 1'b0;
    int send_gap      = 0;
    int stall_left    = 0;
    int cycle_count   = 0;
    int mismatch_count = 0;
    int shapes_taken_count = 0;
    int vertices_checked   = 0;
    int drains_done        = 0;

    regular_polygon_vertex_generator_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .i_rotation     (i_rotation),
        .i_vertex_count (i_vertex_count),
        .i_is_circle    (i_is_circle),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_vertex_index (o_vertex_index),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_last         (o_last)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // model of the corner placement
    // ------------------------------------------------------------------------

    // first quadrant sine in q30: horner taylor series through x^15,
    // each product truncated, then scaled to 32767 full scale with rounding
    function automatic int quarter_wave(input int unsigned m);
        longint arg;
        longint arg_sq;
        longint acc;
        longint prod;
        longint s;
        arg    = (longint'(m) * PI_HALF_Q30 + longint'(ROM_QUARTER / 2)) / ROM_QUARTER;
        arg_sq = (arg * arg) >>> 30;
        acc    = UNITY_Q30;
        for (int n = 7; n >= 1; n--) begin
            prod = (arg_sq * acc) >>> 30;
            acc  = UNITY_Q30 - prod / ((2 * n) * (2 * n + 1));
        end
        s = (arg * acc) >>> 30;
        return int'((longint'(32767) * s + (longint'(1) <<< 29)) >>> 30);
    endfunction

    // center plus scaled trig, floored, clamped to signed 24 bits
    function automatic logic signed [POS_W-1:0] place_coord(input longint center,
                                                            input longint rad,
                                                            input int trig);
        longint sum;
        sum = center + ((rad * longint'(trig)) >>> 15);
        if (sum > COORD_MAX) sum = COORD_MAX;
        if (sum < COORD_MIN) sum = COORD_MIN;
        return sum[POS_W-1:0];
    endfunction

    // one predicted vertex request per corner of the shape
    task automatic expand_shape(input t_shape_req req);
        int unsigned corners;
        int unsigned ang;
        int unsigned k;
        longint      cx;
        longint      cy;
        longint      rad;
        t_vertex     v;
        corners = req.circle ? MAX_VERTICES : int'(req.count);
        if (corners > MAX_VERTICES) corners = MAX_VERTICES;
        cx  = longint'(req.cx);
        cy  = longint'(req.cy);
        rad = longint'({1'b0, req.radius});
        for (int unsigned i = 0; i < corners; i++) begin
            ang     = (int'(req.rot) + ((i << 16) / corners)) & 32'hFFFF;
            k       = ang >> (16 - ROM_BITS);
            v.index = i[VIX_W-1:0];
            v.x     = place_coord(cx, rad, sine_rom[(k + ROM_QUARTER) % ROM_SIZE]);
            v.y     = place_coord(cy, rad, sine_rom[k % ROM_SIZE]);
            v.last  = (i + 1 == corners);
            pending_vertices = {pending_vertices, v};
        end
    endtask

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // idle lengths: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_shape(input logic signed [POS_W-1:0] cx,
                             input logic signed [POS_W-1:0] cy,
                             input logic [RAD_W-1:0] radius,
                             input logic [ANG_W-1:0] rot,
                             input logic [VCNT_W-1:0] count,
                             input logic circle,
                             input bit drain_first,
                             input bit steady);
        t_shape_req req;
        req.cx          = cx;
        req.cy          = cy;
        req.radius      = radius;
        req.rot         = rot;
        req.count       = count;
        req.circle      = circle;
        req.drain_first = drain_first;
        req.steady      = steady;
        shape_backlog = {shape_backlog, req};
    endtask

    // centers lean on the edges now and then so saturation shows up
    function automatic logic signed [POS_W-1:0] rand_center();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 24'h7FFFFF - 24'($urandom_range(0, 4095));
        if (roll == 1) return 24'h800000 + 24'($urandom_range(0, 4095));
        return 24'($urandom());
    endfunction

    function automatic logic [RAD_W-1:0] rand_radius();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) return 23'($urandom_range(0, 4095));
        if (roll < 8) return 23'($urandom());
        if (roll < 9) return 23'h7FFFFF;
        return 23'($urandom_range(0, 3));
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers queued shape requests, changes inputs at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_shape_req nxt;
        if (!i_rst_n) begin
            i_valid        <= 1'b0;
            i_center_x     <= '0;
            i_center_y     <= '0;
            i_radius       <= '0;
            i_rotation     <= '0;
            i_vertex_count <= '0;
            i_is_circle    <= 1'b0;
        end else if (i_valid && !shape_taken) begin
            // request still waiting for o_ready, hold everything
        end else begin
            if (shape_taken) send_gap = flow_steady ? 0 : pick_gap();
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (shape_backlog.size() != 0 &&
                         !(shape_backlog[0].drain_first && pending_vertices.size() != 0)) begin
                nxt = shape_backlog.pop_front();
                if (nxt.drain_first) drains_done++;
                flow_steady    = nxt.steady;
                i_center_x     <= nxt.cx;
                i_center_y     <= nxt.cy;
                i_radius       <= nxt.radius;
                i_rotation     <= nxt.rot;
                i_vertex_count <= nxt.count;
                i_is_circle    <= nxt.circle;
                i_valid        <= 1'b1;
            end else begin
                // nothing to send, or holding off until the scoreboard drains
                i_valid <= 1'b0;
            end
        end
    end

    // receiver side: random stalls on i_ready unless the shape runs steady
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (flow_steady) begin
            stall_left = 0;
            i_ready <= 1'b1;
        end else begin
            if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: takes both handshakes at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_shape_req seen;
        t_vertex    want;
        shape_taken = 1'b0;
        if (i_rst_n) begin
            // shape request accepted: predict its corners from the pins
            if (i_valid && o_ready) begin
                seen.cx     = i_center_x;
                seen.cy     = i_center_y;
                seen.radius = i_radius;
                seen.rot    = i_rotation;
                seen.count  = i_vertex_count;
                seen.circle = i_is_circle;
                expand_shape(seen);
                shape_taken = 1'b1;
                shapes_taken_count++;
            end
            // vertex request accepted: compare against the oldest prediction
            if (o_valid && i_ready) begin
                if (pending_vertices.size() == 0) begin
                    report_mismatch($sformatf("vertex request index %0d with none expected",
                                              o_vertex_index));
                end else begin
                    want = pending_vertices.pop_front();
                    vertices_checked++;
                    if (o_vertex_index !== want.index)
                        report_mismatch($sformatf("vertex_index got %0d want %0d",
                                                  o_vertex_index, want.index));
                    if (o_pos_x !== want.x)
                        report_mismatch($sformatf("pos_x idx %0d got %0d want %0d",
                                                  want.index, o_pos_x, want.x));
                    if (o_pos_y !== want.y)
                        report_mismatch($sformatf("pos_y idx %0d got %0d want %0d",
                                                  want.index, o_pos_y, want.y));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last idx %0d got %0b want %0b",
                                                  want.index, o_last, want.last));
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d vertices still expected",
                     cycle_count, pending_vertices.size());
            $display("** regular_polygon_vertex_generator_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int               roll;
        logic [VCNT_W-1:0] cnt;

        i_rst_n        = 1'b0;

        // sine rom by quadrant symmetry
        for (int k = 0; k < ROM_SIZE; k++) begin
            case (k / ROM_QUARTER)
                0: sine_rom[k] = quarter_wave(k % ROM_QUARTER);
                1: sine_rom[k] = quarter_wave(ROM_QUARTER - k % ROM_QUARTER);
                2: sine_rom[k] = -quarter_wave(k % ROM_QUARTER);
                default: sine_rom[k] = -quarter_wave(ROM_QUARTER - k % ROM_QUARTER);
            endcase
        end

        // directed shapes
        add_shape(24'h000000, 24'h000000, 23'h001000, 16'h0000, 6'd4,  1'b0, 0, 0);
        add_shape(24'h001234, 24'hFFEDCC, 23'h002000, 16'h0000, 6'd0,  1'b0, 0, 0); // empty shape
        add_shape(24'h000100, 24'h000200, 23'h000800, 16'hFFFF, 6'd1,  1'b0, 0, 0);
        add_shape(24'hFFF000, 24'h001000, 23'h004000, 16'h8000, 6'd2,  1'b0, 0, 0);
        add_shape(24'h000000, 24'h000000, 23'h010000, 16'h0001, 6'd3,  1'b0, 0, 0);
        add_shape(24'h012345, 24'hF54321, 23'h0ABCDE, 16'h1234, 6'd32, 1'b0, 0, 0);
        add_shape(24'h000000, 24'h000000, 23'h001000, 16'h0000, 6'd33, 1'b0, 0, 0); // count clamps
        add_shape(24'h000000, 24'h000000, 23'h001000, 16'h4000, 6'd63, 1'b0, 0, 0);
        add_shape(24'h000500, 24'h000500, 23'h000700, 16'h0000, 6'd0,  1'b1, 0, 0); // circle, zero count
        add_shape(24'hFFFB00, 24'h000500, 23'h000700, 16'h2000, 6'd7,  1'b1, 0, 0); // circle overrides
        add_shape(24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 16'h0000, 6'd8,  1'b0, 0, 0); // high saturation
        add_shape(24'h800000, 24'h800000, 23'h7FFFFF, 16'h0000, 6'd8,  1'b0, 0, 0); // low saturation
        add_shape(24'h000000, 24'h000000, 23'h7FFFFF, 16'h7FFF, 6'd16, 1'b0, 0, 0);
        add_shape(24'h000000, 24'h000000, 23'h000001, 16'h0000, 6'd8,  1'b0, 0, 0); // floor to -1
        add_shape(24'h3A5C0F, 24'hC5A3F0, 23'h000000, 16'hABCD, 6'd5,  1'b0, 0, 0); // zero radius
        add_shape(24'h7FFFFF, 24'h800000, 23'h400000, 16'h0000, 6'd6,  1'b0, 0, 0);
        add_shape(24'h800000, 24'h7FFFFF, 23'h400000, 16'hC000, 6'd12, 1'b0, 1, 0); // drain first
        add_shape(24'h000000, 24'h000000, 23'h7FFFFF, 16'h0040, 6'd32, 1'b1, 0, 1);
        add_shape(24'hFFFFFF, 24'hFFFFFF, 23'h000003, 16'h0000, 6'd4,  1'b0, 0, 1);
        add_shape(24'h055555, 24'h0AAAAA, 23'h2AAAAA, 16'h5555, 6'd31, 1'b0, 0, 0);

        // random shapes, a stretch of them with no idling at all
        for (int n = 0; n < RANDOM_SHAPES; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55)      cnt = 6'($urandom_range(0, 10));
            else if (roll < 80) cnt = 6'($urandom_range(11, 32));
            else                cnt = 6'($urandom_range(33, 63));
            add_shape(rand_center(), rand_center(), rand_radius(), 16'($urandom()), cnt,
                      ($urandom_range(0, 7) == 0), ($urandom_range(0, 29) == 0),
                      (n >= 30 && n < 50));
        end

        // single reset at the start
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every shape offered and taken
        while (shape_backlog.size() != 0 || i_valid) @(posedge i_clk);
        // every predicted corner seen
        while (pending_vertices.size() != 0) @(posedge i_clk);
        // let any late or extra vertex request show up
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_vertices.size() != 0)
            report_mismatch($sformatf("%0d vertices never arrived", pending_vertices.size()));

        $display("run covered %0d shape requests and %0d checked vertices, %0d drain pauses,",
                 shapes_taken_count, vertices_checked, drains_done);
        $display("with empty, clamped and circle counts, edge centers and full-scale radii");
        if (mismatch_count == 0) begin
            $display("** regular_polygon_vertex_generator_unit: PASSED **");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("** regular_polygon_vertex_generator_unit: FAILED **");
        end
        $finish;
    end

endmodule
